// ===== hdl/jac_pkg.sv =====
// Shared types and constants for the joystick axis conditioner.
// Used by jac_axis and joystick_axis_conditioner; no dependencies.
`default_nettype none

package jac_pkg;

  // Fraction bits of the Q1.15 result and its full-scale value.
  localparam int unsigned Q_SHIFT = 15;
  localparam int unsigned Q_ONE   = 32767;
  localparam int unsigned OUT_W   = 16;

  // Register reset values in ADC counts.
  localparam int unsigned CENTER_RESET    = 2000;
  localparam int unsigned DEAD_BAND_RESET = 150;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_DEAD_BAND = 2'd2
  } jac_reg_e;

  typedef enum logic [2:0] {
    AX_IDLE,
    AX_READ,
    AX_SUM,
    AX_DIV_AVG,
    AX_CHECK,
    AX_DIV_SCALE,
    AX_DONE
  } jac_axis_state_e;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } jac_top_state_e;

  // Control from the top level to one axis channel.
  typedef struct packed {
    logic start;
    logic ack;
  } jac_axis_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/jac_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by jac_axis; needs nothing from the package.
`default_nettype none

module jac_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] sh_q;
  logic [NUM_W-1:0] sh_d;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   partial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    partial = {rem_q, sh_q[NUM_W-1]};
    diff    = partial - {1'b0, den_q};
    ge      = (partial >= {1'b0, den_q});
    rem_d   = ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
    sh_d    = {sh_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

`default_nettype wire

// ===== hdl/jac_axis.sv =====
// One axis channel: sample ring with running sum, serial mean, deadzone
// and serial Q1.15 scaling. Depends on jac_pkg and jac_div.
`default_nettype none

module jac_axis #(
  parameter int unsigned AVG_DEPTH = 8,
  parameter int unsigned ADC_BITS  = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire jac_pkg::jac_axis_ctl_t        ctl_i,
  input  wire logic                          invert_i,
  input  wire logic [ADC_BITS-1:0]           sample_i,
  input  wire logic [ADC_BITS-1:0]           center_i,
  input  wire logic [ADC_BITS-1:0]           dead_band_i,
  output logic                               done_o,
  output logic [jac_pkg::OUT_W-1:0]          result_o
);

  localparam int unsigned PTR_W   = $clog2(AVG_DEPTH);
  localparam int unsigned CNT_W   = $clog2(AVG_DEPTH + 1);
  localparam int unsigned SUM_W   = ADC_BITS + $clog2(AVG_DEPTH);
  localparam int unsigned SCALE_W = ADC_BITS + jac_pkg::Q_SHIFT;
  localparam int unsigned NUM_W   = (SCALE_W > SUM_W) ? SCALE_W : SUM_W;
  localparam int unsigned DEN_W   = (ADC_BITS > CNT_W) ? ADC_BITS : CNT_W;
  localparam int unsigned OUT_W   = jac_pkg::OUT_W;
  localparam int unsigned Q_SHIFT = jac_pkg::Q_SHIFT;

  jac_pkg::jac_axis_state_e state_q, state_d;

  logic [ADC_BITS-1:0] ring_mem [AVG_DEPTH];
  logic [ADC_BITS-1:0] rd_q;
  logic [ADC_BITS-1:0] sample_q;
  logic [PTR_W-1:0]    slot_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    count_next;
  logic                full;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_d;
  logic [ADC_BITS-1:0] avg_q;
  logic                neg;
  logic                neg_q;
  logic [ADC_BITS-1:0] mag;
  logic [ADC_BITS-1:0] span;
  logic                zero_out;
  logic [NUM_W-1:0]    scale_num;
  logic [Q_SHIFT-1:0]  q_sat;
  logic [OUT_W-1:0]    q_mag;
  logic [OUT_W-1:0]    result_q;

  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;
  logic                mem_we;

  // Running sum: once the ring is full the overwritten entry leaves the sum.
  always_comb begin
    full       = (count_q == CNT_W'(AVG_DEPTH));
    count_next = full ? count_q : count_q + CNT_W'(1);
    sum_d      = sum_q + SUM_W'(sample_q) - (full ? SUM_W'(rd_q) : '0);
  end

  // Offset from the centre, deadzone and the span of the offset's side.
  always_comb begin
    neg       = (avg_q < center_i);
    mag       = neg ? (center_i - avg_q) : (avg_q - center_i);
    span      = neg ? center_i : ~center_i;
    zero_out  = (mag < dead_band_i) || (mag == '0) || (span == '0);
    scale_num = (NUM_W'(mag) << Q_SHIFT) - NUM_W'(mag);
  end

  always_comb begin
    q_sat = (|div_quo[NUM_W-1:Q_SHIFT]) ? Q_SHIFT'(jac_pkg::Q_ONE) : div_quo[Q_SHIFT-1:0];
    q_mag = {1'b0, q_sat};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jac_pkg::AX_IDLE:      if (ctl_i.start) state_d = jac_pkg::AX_READ;
      jac_pkg::AX_READ:      state_d = jac_pkg::AX_SUM;
      jac_pkg::AX_SUM:       state_d = jac_pkg::AX_DIV_AVG;
      jac_pkg::AX_DIV_AVG:   if (div_done) state_d = jac_pkg::AX_CHECK;
      jac_pkg::AX_CHECK:     state_d = zero_out ? jac_pkg::AX_DONE : jac_pkg::AX_DIV_SCALE;
      jac_pkg::AX_DIV_SCALE: if (div_done) state_d = jac_pkg::AX_DONE;
      jac_pkg::AX_DONE:      if (ctl_i.ack) state_d = jac_pkg::AX_IDLE;
      default:               state_d = jac_pkg::AX_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(sum_d);
    div_den   = DEN_W'(count_next);
    mem_we    = 1'b0;
    done_o    = 1'b0;
    unique case (state_q)
      jac_pkg::AX_SUM: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      jac_pkg::AX_CHECK: begin
        div_start = !zero_out;
        div_num   = scale_num;
        div_den   = DEN_W'(span);
      end
      jac_pkg::AX_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jac_pkg::AX_IDLE;
      slot_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        slot_q  <= (slot_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : slot_q + PTR_W'(1);
        count_q <= count_next;
        sum_q   <= sum_d;
      end
    end
  end

  // Ring storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= sample_q;
    end
    rd_q <= ring_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jac_pkg::AX_IDLE && ctl_i.start) begin
      sample_q <= sample_i;
    end
    if (state_q == jac_pkg::AX_DIV_AVG && div_done) begin
      avg_q <= div_quo[ADC_BITS-1:0];
    end
    if (state_q == jac_pkg::AX_CHECK) begin
      neg_q <= neg;
      if (zero_out) begin
        result_q <= '0;
      end
    end
    if (state_q == jac_pkg::AX_DIV_SCALE && div_done) begin
      result_q <= (neg_q ^ invert_i) ? (~q_mag + OUT_W'(1)) : q_mag;
    end
  end

  assign result_o = result_q;

  jac_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

endmodule

`default_nettype wire

// ===== hdl/joystick_axis_conditioner.sv =====
// Top level of the joystick axis conditioner: stream ports, register file,
// output register. Depends on jac_pkg, jac_axis and jac_div.
//
//   Channel  Direction  Handshake                  Payload
//   s_axis   in         s_axis_tvalid/tready       tdata: sample_x, sample_y; tuser: switch_level
//   m_axis   out        m_axis_tvalid/tready       tdata: pos_x, pos_y; tuser: pressed
//   cfg      in         cfg_we_i (no back-pressure) cfg_idx_i, cfg_data_i
//
// Each item is finished before the next input transfer is accepted:
// each axis runs its bit-serial divider for the mean and then for the Q1.15 scaling, both
// axes in parallel. A zero offset, an offset in the dead band or one on a side with no span
// skips that axis's second pass; the item completes once both axes are finished.
// Reset clears the ring pointers, fill counts, running sums and output valid and loads the
// register defaults; ring entries are not cleared. A finished result waits in the output
// register while the next item is accepted; only that item's completion stalls on it.
`default_nettype none

module joystick_axis_conditioner #(
  parameter int unsigned AVG_DEPTH = 8,
  parameter int unsigned ADC_BITS  = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [jac_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ADC_BITS-1:0]              cfg_data_i,
  // Input stream.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata, from bit 0: sample_x, sample_y, zero padding.
  input  wire logic [((2*ADC_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  // tuser: switch_level.
  input  wire logic                             s_axis_tuser_i,
  // Output stream.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata, from bit 0: pos_x, pos_y.
  output logic [2*jac_pkg::OUT_W-1:0]           m_axis_tdata_o,
  // tuser: pressed.
  output logic                                  m_axis_tuser_o
);

  localparam int unsigned OUT_W = jac_pkg::OUT_W;
  localparam logic [ADC_BITS-1:0] CENTER_RST    = ADC_BITS'(jac_pkg::CENTER_RESET);
  localparam logic [ADC_BITS-1:0] DEAD_BAND_RST = ADC_BITS'(jac_pkg::DEAD_BAND_RESET);

  jac_pkg::jac_top_state_e state_q, state_d;
  jac_pkg::jac_axis_ctl_t  axis_ctl;

  logic [ADC_BITS-1:0] center_x_q;
  logic [ADC_BITS-1:0] center_y_q;
  logic [ADC_BITS-1:0] dead_band_q;

  logic                accept;
  logic                load_out;
  logic                x_done;
  logic                y_done;
  logic [OUT_W-1:0]    x_result;
  logic [OUT_W-1:0]    y_result;
  logic                pressed_q;
  logic                m_valid_q;
  logic [2*OUT_W-1:0]  m_data_q;
  logic                m_user_q;

  // Register writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= CENTER_RST;
      center_y_q  <= CENTER_RST;
      dead_band_q <= DEAD_BAND_RST;
    end else if (cfg_we_i) begin
      unique case (jac_pkg::jac_reg_e'(cfg_idx_i))
        jac_pkg::REG_CENTER_X:  center_x_q  <= cfg_data_i;
        jac_pkg::REG_CENTER_Y:  center_y_q  <= cfg_data_i;
        jac_pkg::REG_DEAD_BAND: dead_band_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state: idle until a transfer, busy until both axes are finished and
  // the output register can take the result.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jac_pkg::TOP_IDLE: if (s_axis_tvalid_i) state_d = jac_pkg::TOP_BUSY;
      jac_pkg::TOP_BUSY: if (load_out) state_d = jac_pkg::TOP_IDLE;
      default:           state_d = jac_pkg::TOP_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      jac_pkg::TOP_IDLE: s_axis_tready_o = 1'b1;
      jac_pkg::TOP_BUSY: load_out = x_done && y_done && (!m_valid_q || m_axis_tready_i);
      default: ;
    endcase
  end

  assign accept         = s_axis_tvalid_i && s_axis_tready_o;
  assign axis_ctl.start = accept;
  assign axis_ctl.ack   = load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= jac_pkg::TOP_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // The button is only inverted; it rides along with the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pressed_q <= ~s_axis_tuser_i;
    end
    if (load_out) begin
      m_data_q <= {y_result, x_result};
      m_user_q <= pressed_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  jac_axis #(
    .AVG_DEPTH(AVG_DEPTH),
    .ADC_BITS (ADC_BITS)
  ) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (axis_ctl),
    .invert_i   (1'b0),
    .sample_i   (s_axis_tdata_i[ADC_BITS-1:0]),
    .center_i   (center_x_q),
    .dead_band_i(dead_band_q),
    .done_o     (x_done),
    .result_o   (x_result)
  );

  jac_axis #(
    .AVG_DEPTH(AVG_DEPTH),
    .ADC_BITS (ADC_BITS)
  ) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (axis_ctl),
    .invert_i   (1'b1),
    .sample_i   (s_axis_tdata_i[2*ADC_BITS-1:ADC_BITS]),
    .center_i   (center_y_q),
    .dead_band_i(dead_band_q),
    .done_o     (y_done),
    .result_o   (y_result)
  );

  // A transfer in starts the work; nothing else is taken until it is done.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == jac_pkg::TOP_BUSY))
    else $error("accepted item did not start processing");

  // Both axes must agree on completion when a result is loaded.
  a_load_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (x_done && y_done))
    else $error("result loaded before both axes finished");

  // A stalled result stays put until the receiver takes it.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=>
      (m_valid_q && $stable(m_data_q) && $stable(m_user_q)))
    else $error("output transfer changed while stalled");

  // Saturated Q1.15 never reaches the most negative code.
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[OUT_W-1:0] != {1'b1, {(OUT_W-1){1'b0}}}) &&
                  (m_data_q[2*OUT_W-1:OUT_W] != {1'b1, {(OUT_W-1){1'b0}}}))
    else $error("position outside the Q1.15 range");

endmodule

`default_nettype wire
